FILE: src/ald_pkg.sv
// Shared types and codes for the address lock directory.
package ald_pkg;

  localparam int FUNC_BITS   = 3;
  localparam int STATUS_BITS = 3;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_READ  = 3'd0,
    FN_WRITE = 3'd1,
    FN_OTHER = 3'd2,
    FN_RESP  = 3'd3,
    FN_SCAN  = 3'd4
  } func_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_UNHELD  = 3'd2,
    ST_NOROUTE = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_SCAN,
    S_SOUT,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic look;       // search held table, read route
    logic exec;       // perform the single-word command
    logic scan_start; // reset scan pointers
    logic scan_eval;  // evaluate queue entry at read pointer
    logic scan_step;  // commit entry result, advance
    logic out_take;   // result word consumed
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_scan;
    logic       scan_done;  // read pointer reached count
    logic       entry_issue;
    logic       any_issued;
  } dp_stat_t;

endpackage

FILE: src/ald_ctrl.sv
// Controller state machine for the address lock directory.
module ald_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_last,
  input  ald_pkg::dp_stat_t stat,
  output ald_pkg::dp_cmd_t  cmd
);
  import ald_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (stat.is_scan) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_OUT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_OUT;
        end else begin
          cmd.scan_eval = 1'b1;
          state_next = S_SOUT;
        end
      end
      S_SOUT: begin
        // a new issue first flushes the word held from the previous issue
        if (stat.entry_issue && stat.any_issued) begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.out_take = 1'b1;
            cmd.scan_step = 1'b1;
            state_next = S_SCAN;
          end
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_OUT: begin
        // final word: the last issued read, or the plain result
        out_valid = 1'b1;
        out_last = 1'b1;
        if (out_ready) begin
          cmd.out_take = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: src/ald_dp.sv
// Datapath: held table, pending queue, route table and result register.
module ald_dp #(
  parameter int HELD_DEPTH    = 16,
  parameter int PENDING_DEPTH = 16,
  parameter int TAG_BITS      = 8,
  parameter int ADDR_BITS     = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ald_pkg::dp_cmd_t      cmd,
  output ald_pkg::dp_stat_t     stat,
  input  logic [2:0]            in_func,
  input  logic [ADDR_BITS-1:0]  in_addr,
  input  logic                  in_port,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  logic                  in_rwr,
  input  logic                  in_blocked,
  output logic [2:0]            o_status,
  output logic                  o_issue,
  output logic [ADDR_BITS-1:0]  o_addr,
  output logic [TAG_BITS-1:0]   o_tag,
  output logic                  o_wr,
  output logic                  o_rvalid,
  output logic                  o_rport,
  output logic [TAG_BITS-1:0]   o_rtag
);
  import ald_pkg::*;

  localparam int HB = $clog2(HELD_DEPTH);
  localparam int PB = $clog2(PENDING_DEPTH);
  localparam int CB = $clog2(PENDING_DEPTH + 1);
  localparam int RD = 1 << TAG_BITS;

  logic [2:0]           func;
  logic [ADDR_BITS-1:0] addr;
  logic                 port;
  logic [TAG_BITS-1:0]  tag;
  logic                 rwr, blocked;

  logic [HELD_DEPTH-1:0] held_valid;
  logic [ADDR_BITS-1:0]  held_addr [HELD_DEPTH];
  logic [ADDR_BITS-1:0]  pend_addr [PENDING_DEPTH];
  logic                  pend_port [PENDING_DEPTH];
  logic [TAG_BITS-1:0]   pend_tag  [PENDING_DEPTH];
  logic [CB-1:0]         pend_count;
  logic [RD-1:0]         route_valid;
  logic [RD-1:0]         route_port;

  // lookup results
  logic          hit;
  logic [HB-1:0] hit_idx;
  logic          rt_v, rt_p;
  logic [CB-1:0] rp, wp;
  logic          any_issued, entry_issue;

  // held table search, registered in LOOK / SCAN eval
  logic          s_hit, s_free;
  logic [HB-1:0] s_hidx, s_fidx;
  logic [ADDR_BITS-1:0] s_addr;

  assign s_addr = cmd.scan_eval ? pend_addr[rp[PB-1:0]] : addr;

  always_comb begin
    s_hit = 1'b0;
    s_hidx = '0;
    s_free = 1'b0;
    s_fidx = '0;
    for (int i = HELD_DEPTH - 1; i >= 0; i--) begin
      if (held_valid[i] && held_addr[i] == s_addr) begin
        s_hit = 1'b1;
        s_hidx = HB'(i);
      end
      if (!held_valid[i]) begin
        s_free = 1'b1;
        s_fidx = HB'(i);
      end
    end
  end

  assign stat.is_scan     = (func == FN_SCAN);
  assign stat.scan_done   = (rp == pend_count);
  assign stat.entry_issue = entry_issue;
  assign stat.any_issued  = any_issued;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      addr <= in_addr;
      port <= in_port;
      tag <= in_tag;
      rwr <= in_rwr;
      blocked <= in_blocked;
      o_status <= ST_OK;
      o_issue <= 1'b0;
      o_addr <= '0;
      o_tag <= '0;
      o_wr <= 1'b0;
      o_rvalid <= 1'b0;
      o_rport <= 1'b0;
      o_rtag <= '0;
    end
    if (cmd.look) begin
      hit <= s_hit;
      hit_idx <= s_hidx;
      rt_v <= route_valid[tag];
      rt_p <= route_port[tag];
    end
    if (cmd.scan_eval) begin
      entry_issue <= !blocked && !s_hit && s_free;
      hit_idx <= s_fidx;
    end
    if (cmd.out_take && !cmd.scan_step) begin
      o_issue <= 1'b0;
    end
    if (cmd.scan_start) begin
      o_issue <= 1'b0;
      o_addr <= '0;
      o_tag <= '0;
    end
    if (cmd.exec) begin
      unique case (func)
        FN_READ: begin
          if (pend_count < CB'(PENDING_DEPTH)) begin
            pend_addr[pend_count[PB-1:0]] <= addr;
            pend_port[pend_count[PB-1:0]] <= port;
            pend_tag[pend_count[PB-1:0]] <= tag;
          end else begin
            o_status <= ST_FULL;
          end
        end
        FN_WRITE: begin
          if (!hit) o_status <= ST_UNHELD;
          else if (blocked) o_status <= ST_BUSY;
          else begin
            route_port[tag] <= port;
            o_issue <= 1'b1;
            o_addr <= addr;
            o_tag <= tag;
            o_wr <= 1'b1;
          end
        end
        FN_OTHER: begin
          if (blocked) o_status <= ST_BUSY;
          else begin
            o_issue <= 1'b1;
            o_addr <= addr;
            o_tag <= tag;
          end
        end
        FN_RESP: begin
          if (!rwr && rt_v) begin
            o_rvalid <= 1'b1;
            o_rport <= rt_p;
            o_rtag <= tag;
          end else if (!rwr) begin
            o_status <= ST_NOROUTE;
          end
        end
        default: ;
      endcase
    end
    if (cmd.scan_step) begin
      // an issued read waits in the result register until the next issue or the end
      if (entry_issue) begin
        held_addr[hit_idx] <= pend_addr[rp[PB-1:0]];
        route_port[pend_tag[rp[PB-1:0]]] <= pend_port[rp[PB-1:0]];
        o_issue <= 1'b1;
        o_addr <= pend_addr[rp[PB-1:0]];
        o_tag <= pend_tag[rp[PB-1:0]];
      end else begin
        pend_addr[wp[PB-1:0]] <= pend_addr[rp[PB-1:0]];
        pend_port[wp[PB-1:0]] <= pend_port[rp[PB-1:0]];
        pend_tag[wp[PB-1:0]] <= pend_tag[rp[PB-1:0]];
      end
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= '0;
      route_valid <= '0;
      pend_count <= '0;
      rp <= '0;
      wp <= '0;
      any_issued <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (func)
          FN_READ: if (pend_count < CB'(PENDING_DEPTH)) pend_count <= pend_count + 1'b1;
          FN_WRITE: if (hit && !blocked) begin
            held_valid[hit_idx] <= 1'b0;
            route_valid[tag] <= 1'b1;
          end
          FN_RESP: route_valid[tag] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        rp <= '0;
        wp <= '0;
        any_issued <= 1'b0;
      end
      if (cmd.scan_step) begin
        rp <= rp + 1'b1;
        if (entry_issue) begin
          held_valid[hit_idx] <= 1'b1;
          route_valid[pend_tag[rp[PB-1:0]]] <= 1'b1;
          any_issued <= 1'b1;
        end else begin
          wp <= wp + 1'b1;
        end
      end
      // queue shrinks to kept entries when the walk ends
      if (stat.is_scan && stat.scan_done && !cmd.scan_start && !cmd.look && !cmd.load
          && rp != '0 && !cmd.scan_eval) begin
        pend_count <= wp;
        rp <= '0;
        wp <= '0;
      end
    end
  end
endmodule

FILE: src/address_lock_directory_core.sv
// Top level of the address lock directory.
//
//  channel | dir | handshake          | payload
//  s_axis  | in  | s_axis_t{valid,ready} | tdata: func, addr, port, tag, resp_is_write, mem_blocked
//  m_axis  | out | m_axis_t{valid,ready} | tdata: status..resp_tag, tlast: last
//
// One word at a time. A non-scan word passes through the look and exec states
// and then waits in the output state. A scan walks the queue entry by entry,
// evaluating and then committing each, and stalls on issued words. Each issued
// read is held back one entry so the final one goes out with tlast.
// Synchronous active-high reset clears the held, route and queue valid state.
// Output stalls hold the result register and the walk.
module address_lock_directory_core #(
  parameter int HELD_DEPTH    = 16,
  parameter int PENDING_DEPTH = 16,
  parameter int TAG_BITS      = 8,
  parameter int ADDR_BITS     = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // func, addr, port, tag, resp_is_write, mem_blocked (low bit up), zero fill
  input  logic [((3 + ADDR_BITS + 1 + TAG_BITS + 2 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status, mem_issue, mem_addr, mem_tag, mem_is_write, resp_valid, resp_port,
  // resp_tag (low bit up), zero fill
  output logic [((3 + 1 + ADDR_BITS + TAG_BITS + 3 + TAG_BITS + 7) / 8) * 8 - 1:0]
               m_axis_tdata,
  output logic m_axis_tlast
);
  import ald_pkg::*;

  localparam int IW = ((3 + ADDR_BITS + 1 + TAG_BITS + 2 + 7) / 8) * 8;
  localparam int OB = 3 + 1 + ADDR_BITS + TAG_BITS + 3 + TAG_BITS;
  localparam int OW = ((OB + 7) / 8) * 8;
  localparam int A0 = 3;
  localparam int P0 = A0 + ADDR_BITS;
  localparam int T0 = P0 + 1;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [2:0]           o_status;
  logic                 o_issue, o_wr, o_rvalid, o_rport;
  logic [ADDR_BITS-1:0] o_addr;
  logic [TAG_BITS-1:0]  o_tag, o_rtag;

  ald_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_last(m_axis_tlast), .stat, .cmd
  );

  ald_dp #(
    .HELD_DEPTH(HELD_DEPTH), .PENDING_DEPTH(PENDING_DEPTH),
    .TAG_BITS(TAG_BITS), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_func(s_axis_tdata[2:0]),
    .in_addr(s_axis_tdata[P0-1:A0]),
    .in_port(s_axis_tdata[P0]),
    .in_tag(s_axis_tdata[T0+TAG_BITS-1:T0]),
    .in_rwr(s_axis_tdata[T0+TAG_BITS]),
    .in_blocked(s_axis_tdata[T0+TAG_BITS+1]),
    .o_status, .o_issue, .o_addr, .o_tag, .o_wr, .o_rvalid, .o_rport, .o_rtag
  );

  assign m_axis_tdata = OW'({o_rtag, o_rport, o_rvalid, o_wr, o_tag, o_addr, o_issue,
                             o_status});

  logic unused_in;
  assign unused_in = ^s_axis_tdata[IW-1:T0+TAG_BITS+2] | 1'b0;
endmodule

FILE: src/ald_checker.sv
// Port-level checks for the address lock directory.
module ald_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);
  // one word in flight: no input taken while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready while output valid");
  // accepted word produces no result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tlast)))
    else $error("output dropped under stall");
endmodule

bind address_lock_directory_core ald_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tlast
);

FILE: verif/tb.sv
// Testbench for address_lock_directory_core: random and directed words checked by a scoreboard.
`timescale 1ns / 100ps

import ald_pkg::*;

typedef struct {
  logic [2:0]  status;
  logic        issue;
  logic [47:0] maddr;
  logic [7:0]  mtag;
  logic        mwr;
  logic        rvalid;
  logic        rport;
  logic [7:0]  rtag;
  logic        last;
} dir_result_t;

class lock_scoreboard;
  bit          held_v[16];
  logic [47:0] held_a[16];
  logic [47:0] pend_a[16];
  logic        pend_p[16];
  logic [7:0]  pend_t[16];
  int          pend_n;
  bit          route_v[256];
  logic        route_p[256];
  dir_result_t pending_results[$];
  int          errors;

  function int find_held(logic [47:0] a);
    for (int i = 0; i < 16; i++) if (held_v[i] && held_a[i] == a) return i;
    return -1;
  endfunction

  function int free_slot();
    for (int i = 0; i < 16; i++) if (!held_v[i]) return i;
    return -1;
  endfunction

  function void push(logic [2:0] st, logic iss, logic [47:0] ma, logic [7:0] mt,
                     logic mw, logic rv, logic rp, logic [7:0] rt);
    dir_result_t r;
    r.status = st; r.issue = iss; r.maddr = ma; r.mtag = mt; r.mwr = mw;
    r.rvalid = rv; r.rport = rp; r.rtag = rt; r.last = 0;
    pending_results = {pending_results, r};
  endfunction

  // Predict the result words caused by one accepted input word.
  function void note_word(logic [63:0] d);
    logic [2:0]  fn;
    logic [47:0] a;
    logic        p, rw, blk;
    logic [7:0]  t;
    int          h, w, issued, s;
    fn = d[2:0]; a = d[50:3]; p = d[51]; t = d[59:52]; rw = d[60]; blk = d[61];
    case (fn)
      FN_READ: begin
        if (pend_n < 16) begin
          pend_a[pend_n] = a; pend_p[pend_n] = p; pend_t[pend_n] = t;
          pend_n++;
          push(ST_OK, 0, 0, 0, 0, 0, 0, 0);
        end else push(ST_FULL, 0, 0, 0, 0, 0, 0, 0);
      end
      FN_WRITE: begin
        h = find_held(a);
        if (h < 0) push(ST_UNHELD, 0, 0, 0, 0, 0, 0, 0);
        else if (blk) push(ST_BUSY, 0, 0, 0, 0, 0, 0, 0);
        else begin
          held_v[h] = 0; route_v[t] = 1; route_p[t] = p;
          push(ST_OK, 1, a, t, 1, 0, 0, 0);
        end
      end
      FN_OTHER: begin
        if (blk) push(ST_BUSY, 0, 0, 0, 0, 0, 0, 0);
        else push(ST_OK, 1, a, t, 0, 0, 0, 0);
      end
      FN_RESP: begin
        if (rw) begin
          route_v[t] = 0; push(ST_OK, 0, 0, 0, 0, 0, 0, 0);
        end else if (route_v[t]) begin
          route_v[t] = 0; push(ST_OK, 0, 0, 0, 0, 1, route_p[t], t);
        end else push(ST_NOROUTE, 0, 0, 0, 0, 0, 0, 0);
      end
      FN_SCAN: begin
        w = 0; issued = 0;
        for (int r = 0; r < pend_n; r++) begin
          s = -1;
          if (!blk && issued < 16 && find_held(pend_a[r]) < 0) s = free_slot();
          if (s >= 0) begin
            held_v[s] = 1; held_a[s] = pend_a[r];
            route_v[pend_t[r]] = 1; route_p[pend_t[r]] = pend_p[r];
            push(ST_OK, 1, pend_a[r], pend_t[r], 0, 0, 0, 0);
            issued++;
          end else begin
            pend_a[w] = pend_a[r]; pend_p[w] = pend_p[r]; pend_t[w] = pend_t[r];
            w++;
          end
        end
        pend_n = w;
        if (issued == 0) push(ST_OK, 0, 0, 0, 0, 0, 0, 0);
      end
      default: push(ST_OK, 0, 0, 0, 0, 0, 0, 0);
    endcase
    pending_results[$].last = 1;
  endfunction

  function void check_word(logic [71:0] d, logic lst);
    dir_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result word %h", d);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (d[2:0] !== e.status) begin
      $error("status exp %0d got %0d", e.status, d[2:0]); errors++;
    end
    if (d[3] !== e.issue) begin
      $error("mem_issue exp %0d got %0d", e.issue, d[3]); errors++;
    end
    if (d[51:4] !== e.maddr) begin
      $error("mem_addr exp %h got %h", e.maddr, d[51:4]); errors++;
    end
    if (d[59:52] !== e.mtag) begin
      $error("mem_tag exp %h got %h", e.mtag, d[59:52]); errors++;
    end
    if (d[60] !== e.mwr) begin
      $error("mem_is_write exp %0d got %0d", e.mwr, d[60]); errors++;
    end
    if (d[61] !== e.rvalid) begin
      $error("resp_valid exp %0d got %0d", e.rvalid, d[61]); errors++;
    end
    if (d[62] !== e.rport) begin
      $error("resp_port exp %0d got %0d", e.rport, d[62]); errors++;
    end
    if (d[70:63] !== e.rtag) begin
      $error("resp_tag exp %h got %h", e.rtag, d[70:63]); errors++;
    end
    if (lst !== e.last) begin
      $error("last exp %0d got %0d", e.last, lst); errors++;
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  lock_scoreboard sb = new();
  bit             stim_done = 0;
  logic [47:0]    addr_pool[8];

  address_lock_directory_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic logic [63:0] pack_word(logic [2:0] fn, logic [47:0] a, logic p,
                                            logic [7:0] t, logic rw, logic blk);
    return {2'b00, blk, rw, t, p, a, fn};
  endfunction

  // Gap, then hold the word until accepted; valid stays high into a zero gap.
  task automatic send_word(logic [63:0] d);
    int g;
    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(d);
  endtask

  task automatic send_rand();
    logic [2:0]  fn;
    logic [47:0] a;
    logic [7:0]  t;
    logic        blk;
    int          k, h;
    k   = $urandom_range(0, 99);
    blk = ($urandom_range(0, 4) == 0);
    a   = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                                      : addr_pool[$urandom_range(0, 7)];
    t   = 8'($urandom_range(0, 255));
    if (k < 35) fn = FN_READ;
    else if (k < 55) fn = FN_SCAN;
    else if (k < 72) begin
      fn = FN_WRITE;
      h = $urandom_range(0, 15);
      if (sb.held_v[h] && $urandom_range(0, 4) != 0) a = sb.held_a[h];
    end else if (k < 90) begin
      fn = FN_RESP;
      for (int i = 0; i < 256; i++)
        if (sb.route_v[(t + i) % 256] && $urandom_range(0, 3) != 0) begin
          t = 8'((t + i) % 256);
          break;
        end
    end else if (k < 96) fn = FN_OTHER;
    else fn = 3'($urandom_range(5, 7));
    send_word(pack_word(fn, a, 1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1)),
                        blk));
  endtask

  // Receiver: random stall per word, check on every accepted word.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) addr_pool[i] = 48'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, every func, special cases
    send_word(pack_word(FN_RESP, 48'h0, 0, 8'h00, 0, 0));        // read resp, no route
    send_word(pack_word(FN_WRITE, '1, 1, 8'hff, 0, 0));          // write to unheld
    send_word(pack_word(FN_OTHER, '1, 1, 8'hff, 0, 1));          // other, blocked
    send_word(pack_word(FN_OTHER, '1, 1, 8'hff, 1, 0));          // other, forwarded
    for (int i = 0; i < 17; i++)                                  // last one hits queue full
      send_word(pack_word(FN_READ, (i == 0) ? 48'h0 : (i == 1) ? '1 : 48'(i * 7919),
                          i[0], 8'(i), 0, 0));
    send_word(pack_word(FN_SCAN, 0, 0, 0, 0, 1));                // blocked scan
    send_word(pack_word(FN_SCAN, 0, 0, 0, 0, 0));                // issue sixteen
    send_word(pack_word(FN_READ, 48'h5, 1, 8'h80, 0, 0));
    send_word(pack_word(FN_SCAN, 0, 0, 0, 0, 0));                // every slot held
    send_word(pack_word(FN_WRITE, '1, 1, 8'h01, 0, 1));          // write, blocked
    send_word(pack_word(FN_WRITE, '1, 0, 8'h01, 0, 0));          // release
    send_word(pack_word(FN_RESP, 0, 0, 8'h01, 1, 0));            // write ack
    send_word(pack_word(FN_RESP, 0, 0, 8'h00, 0, 0));            // routed read data
    send_word(pack_word(3'd7, '1, 1, 8'hff, 1, 1));              // unused code
    send_word(pack_word(FN_SCAN, 0, 0, 0, 0, 0));
    for (int i = 0; i < 100; i++) begin
      if (i == 60) begin
        // hold off until the block has drained
        s_axis_tvalid <= 0;
        wait (sb.pending_results.size() == 0);
        @(posedge clk);
      end
      send_rand();
    end
    s_axis_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (sb.pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: filelist.f
src/ald_pkg.sv
src/ald_ctrl.sv
src/ald_dp.sv
src/address_lock_directory_core.sv
src/ald_checker.sv
verif/tb.sv
